[design/bpc_pkg.sv]
// ----------------------------------------------------------------------------
// bpc_pkg - shared types and constants for the barometric compensation block
// Calibration word bundle, register indexes and the fixed temperature and
// pressure limits used by the compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int RAW_W   = 24;
	localparam int COEFF_W = 16;
	localparam int REG_IDX_W = 3;
	localparam int TEMP_W  = 15;
	localparam int PRESS_W = 17;

	// depth of the compensation pipeline
	localparam int NSTG = 10;

	// register indexes of the calibration words
	localparam logic [REG_IDX_W-1:0] REG_SENS        = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SENS_TC     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_TC   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_REF_TEMP    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_TEMP_SLOPE  = 3'd5;

	// temperature thresholds in 0.01 C, on the unsaturated 19-bit value
	localparam logic signed [18:0] TEMP_REF   = 19'sd2000;
	localparam logic signed [18:0] TEMP_XCOLD = -19'sd1500;

	// output limits
	localparam logic signed [TEMP_W-1:0] TEMP_LO = -15'sd4000;
	localparam logic signed [TEMP_W-1:0] TEMP_HI = 15'sd8500;
	localparam logic [PRESS_W-1:0] PRESS_HI = 17'd131071;

	typedef struct packed {
		logic [COEFF_W-1:0] sens;
		logic [COEFF_W-1:0] offset;
		logic [COEFF_W-1:0] sens_tc;
		logic [COEFF_W-1:0] offset_tc;
		logic [COEFF_W-1:0] ref_temp;
		logic [COEFF_W-1:0] temp_slope;
	} coeff_t;

endpackage

[design/baro_pressure_temp_compensation.sv]
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation - second-order sensor compensation
// Ten-stage pipeline turning raw pressure and temperature readings into
// saturated temperature (0.01 C) and pressure (0.01 mbar).
// ----------------------------------------------------------------------------
// The block accepts one pair of raw readings per clock while the output
// side is not stalled and delivers the results in order. The ten register
// stages are: reference subtract, the three 25x17 calibration products,
// offset and sensitivity sums, the two squares for the cold-range terms,
// the second-order terms, the corrections, the split 24x41 pressure product
// (two partial products), their recombination, the offset subtract and the
// final saturation. Each stage advances whenever it is empty or the stage
// after it advances, so a stall on the output fills bubbles first and only
// then stalls the input. Calibration words sit at indexes 0..5 of the
// configuration channel, which is always ready; write them only while no
// item is in flight. A zero raw reading yields valid_res low with both
// result fields zero.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [bpc_pkg::RAW_W-1:0]             raw_pressure,
	input  logic [bpc_pkg::RAW_W-1:0]             raw_temperature,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [bpc_pkg::TEMP_W-1:0]     temp_centideg,
	output logic [bpc_pkg::PRESS_W-1:0]           press_centimbar,
	output logic                                  valid_res,
	// configuration channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bpc_pkg::REG_IDX_W-1:0]         cfg_index,
	input  logic [bpc_pkg::COEFF_W-1:0]           cfg_data
);

	bpc_pkg::coeff_t coeff;

	bpc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coeff     (coeff)
	);

	// ------------------------------------------------------------------
	// Pipeline flow control: a stage advances when empty or when its
	// successor advances; the last stage advances unless the output stalls.
	// ------------------------------------------------------------------
	logic [bpc_pkg::NSTG:1] vld_q;
	logic [bpc_pkg::NSTG:1] adv;

	always_comb begin
		adv[bpc_pkg::NSTG] = !vld_q[bpc_pkg::NSTG] || !out_stall;
		for (int k = bpc_pkg::NSTG - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_stall  = !adv[1];
	assign out_valid = vld_q[bpc_pkg::NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) vld_q[1] <= in_valid;
			for (int k = 2; k <= bpc_pkg::NSTG; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: difference to the reference temperature, zero-reading flag
	// ------------------------------------------------------------------
	logic signed [24:0] dt_s1;
	logic [23:0]        d1_s1;
	logic               zero_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			dt_s1   <= $signed({1'b0, raw_temperature})
			         - $signed({1'b0, coeff.ref_temp, 8'b0});
			d1_s1   <= raw_pressure;
			zero_s1 <= (raw_pressure == '0) || (raw_temperature == '0);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: dT times the offset, sensitivity and temperature slopes
	// ------------------------------------------------------------------
	logic signed [40:0] p4_s2, p3_s2, p6_s2;
	logic [23:0]        d1_s2;
	logic               zero_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			p4_s2   <= dt_s1 * $signed({1'b0, coeff.offset_tc});
			p3_s2   <= dt_s1 * $signed({1'b0, coeff.sens_tc});
			p6_s2   <= dt_s1 * $signed({1'b0, coeff.temp_slope});
			d1_s2   <= d1_s1;
			zero_s2 <= zero_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: first-order offset, sensitivity and temperature. Taking the
	// upper bits of a signed product is the floor shift.
	// ------------------------------------------------------------------
	logic signed [17:0] tdelta_s3;
	logic signed [18:0] temp_s3;
	logic signed [18:0] tp_s3;
	logic signed [35:0] off1_s3;
	logic signed [34:0] sens1_s3;
	logic [23:0]        d1_s3;
	logic               zero_s3;
	logic signed [17:0] tdelta_c;
	logic signed [18:0] temp_c;

	assign tdelta_c = $signed(p6_s2[40:23]);
	assign temp_c   = bpc_pkg::TEMP_REF + 19'(tdelta_c);

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			tdelta_s3 <= tdelta_c;
			temp_s3   <= temp_c;
			tp_s3     <= temp_c - bpc_pkg::TEMP_XCOLD;
			off1_s3   <= $signed({4'b0, coeff.offset, 16'b0}) + 36'($signed(p4_s2[40:7]));
			sens1_s3  <= $signed({4'b0, coeff.sens, 15'b0}) + 35'($signed(p3_s2[40:8]));
			d1_s3     <= d1_s2;
			zero_s3   <= zero_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: squares for the cold-range terms, range flags, saturated
	// temperature
	// ------------------------------------------------------------------
	logic [35:0]                       sq1_s4;
	logic [34:0]                       sq2_s4;
	logic                              cold_s4, xcold_s4;
	logic signed [bpc_pkg::TEMP_W-1:0] temp_s4;
	logic signed [35:0]                off1_s4;
	logic signed [34:0]                sens1_s4;
	logic [23:0]                       d1_s4;
	logic                              zero_s4;
	logic signed [35:0]                sq1_c;
	logic signed [37:0]                sq2_c;
	logic signed [bpc_pkg::TEMP_W-1:0] temp_sat_c;

	assign sq1_c = tdelta_s3 * tdelta_s3;
	assign sq2_c = tp_s3 * tp_s3;

	always_comb begin
		if (temp_s3 < bpc_pkg::TEMP_LO)      temp_sat_c = bpc_pkg::TEMP_LO;
		else if (temp_s3 > bpc_pkg::TEMP_HI) temp_sat_c = bpc_pkg::TEMP_HI;
		else                                 temp_sat_c = temp_s3[bpc_pkg::TEMP_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			sq1_s4   <= sq1_c;
			// only used in the very cold range, where it fits 35 bits
			sq2_s4   <= sq2_c[34:0];
			cold_s4  <= temp_s3 < bpc_pkg::TEMP_REF;
			xcold_s4 <= temp_s3 < bpc_pkg::TEMP_XCOLD;
			temp_s4  <= temp_sat_c;
			off1_s4  <= off1_s3;
			sens1_s4 <= sens1_s3;
			d1_s4    <= d1_s3;
			zero_s4  <= zero_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: second-order offset and sensitivity terms
	// ------------------------------------------------------------------
	logic [38:0]                       off2_s5, sens2_s5;
	logic signed [bpc_pkg::TEMP_W-1:0] temp_s5;
	logic signed [35:0]                off1_s5;
	logic signed [34:0]                sens1_s5;
	logic [23:0]                       d1_s5;
	logic                              zero_s5;
	logic [39:0]                       five_sq1, seven_sq2, eleven_sq2;
	logic [39:0]                       off2_c, sens2_c;

	always_comb begin
		five_sq1   = (40'(sq1_s4) << 2) + 40'(sq1_s4);
		seven_sq2  = (40'(sq2_s4) << 3) - 40'(sq2_s4);
		eleven_sq2 = (40'(sq2_s4) << 3) + (40'(sq2_s4) << 1) + 40'(sq2_s4);
		off2_c     = '0;
		sens2_c    = '0;
		if (cold_s4) begin
			off2_c  = five_sq1 >> 1;
			sens2_c = five_sq1 >> 2;
			if (xcold_s4) begin
				off2_c  = off2_c + seven_sq2;
				sens2_c = sens2_c + (eleven_sq2 >> 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			off2_s5  <= off2_c[38:0];
			sens2_s5 <= sens2_c[38:0];
			temp_s5  <= temp_s4;
			off1_s5  <= off1_s4;
			sens1_s5 <= sens1_s4;
			d1_s5    <= d1_s4;
			zero_s5  <= zero_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: apply the corrections
	// ------------------------------------------------------------------
	logic signed [40:0]                off_s6, sens_s6;
	logic signed [bpc_pkg::TEMP_W-1:0] temp_s6;
	logic [23:0]                       d1_s6;
	logic                              zero_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			off_s6  <= 41'(off1_s5) - $signed({2'b0, off2_s5});
			sens_s6 <= 41'(sens1_s5) - $signed({2'b0, sens2_s5});
			temp_s6 <= temp_s5;
			d1_s6   <= d1_s5;
			zero_s6 <= zero_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: D1 times sensitivity as two partial products
	// ------------------------------------------------------------------
	logic [43:0]                       pp_lo_s7;
	logic signed [44:0]                pp_hi_s7;
	logic signed [40:0]                off_s7;
	logic signed [bpc_pkg::TEMP_W-1:0] temp_s7;
	logic                              zero_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			pp_lo_s7 <= d1_s6 * sens_s6[19:0];
			pp_hi_s7 <= $signed({1'b0, d1_s6}) * $signed(sens_s6[40:20]);
			off_s7   <= off_s6;
			temp_s7  <= temp_s6;
			zero_s7  <= zero_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: recombine the partial products
	// ------------------------------------------------------------------
	logic signed [64:0]                prod_s8;
	logic signed [40:0]                off_s8;
	logic signed [bpc_pkg::TEMP_W-1:0] temp_s8;
	logic                              zero_s8;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			prod_s8 <= (65'(pp_hi_s7) <<< 20) + $signed({21'b0, pp_lo_s7});
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;
			zero_s8 <= zero_s7;
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: scaled product minus offset
	// ------------------------------------------------------------------
	logic signed [44:0]                diff_s9;
	logic signed [bpc_pkg::TEMP_W-1:0] temp_s9;
	logic                              zero_s9;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			diff_s9 <= 45'($signed(prod_s8[64:21])) - 45'(off_s8);
			temp_s9 <= temp_s8;
			zero_s9 <= zero_s8;
		end
	end

	// ------------------------------------------------------------------
	// Stage 10: final shift, saturation and the zero-reading override;
	// this is the output register.
	// ------------------------------------------------------------------
	logic signed [29:0]           press_c;
	logic [bpc_pkg::PRESS_W-1:0]  press_sat_c;

	assign press_c = $signed(diff_s9[44:15]);

	always_comb begin
		if (press_c < 0)                            press_sat_c = '0;
		else if (press_c > 30'(bpc_pkg::PRESS_HI))  press_sat_c = bpc_pkg::PRESS_HI;
		else                                        press_sat_c = press_c[bpc_pkg::PRESS_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			if (zero_s9) begin
				temp_centideg   <= '0;
				press_centimbar <= '0;
				valid_res       <= 1'b0;
			end else begin
				temp_centideg   <= temp_s9;
				press_centimbar <= press_sat_c;
				valid_res       <= 1'b1;
			end
		end
	end

endmodule

[design/bpc_regs.sv]
// ----------------------------------------------------------------------------
// bpc_regs - calibration word registers
// Six 16-bit words written through the configuration channel; writes to an
// index past the list are dropped.
// ----------------------------------------------------------------------------
module bpc_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bpc_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [bpc_pkg::COEFF_W-1:0]    cfg_data,
	output bpc_pkg::coeff_t                coeff
);

	bpc_pkg::coeff_t coeff_q;

	assign cfg_ready = 1'b1;
	assign coeff     = coeff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bpc_pkg::REG_SENS:       coeff_q.sens       <= cfg_data;
				bpc_pkg::REG_OFFSET:     coeff_q.offset     <= cfg_data;
				bpc_pkg::REG_SENS_TC:    coeff_q.sens_tc    <= cfg_data;
				bpc_pkg::REG_OFFSET_TC:  coeff_q.offset_tc  <= cfg_data;
				bpc_pkg::REG_REF_TEMP:   coeff_q.ref_temp   <= cfg_data;
				bpc_pkg::REG_TEMP_SLOPE: coeff_q.temp_slope <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb - self-checking bench for baro_pressure_temp_compensation
// Drives raw pressure/temperature pairs with random gaps and output stalls,
// predicts each compensated reading in 64-bit integer math and compares it
// field by field, across several calibration settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

	// ------------------------------------------------------------------------
	// Bench constants
	// ------------------------------------------------------------------------
	localparam int IDLE_PCT     = 20;    // percent of cycles a side idles
	localparam int CALM_LO      = 400;   // beats in [CALM_LO, CALM_HI) never idle
	localparam int CALM_HI      = 700;
	localparam int HOLD_A       = 900;   // readings after which the sink holds off
	localparam int HOLD_B       = 1250;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 350;
	localparam int PHASES       = 5;
	localparam int TAIL_CYCLES  = 30;    // well past the ten-stage pipeline depth

	// spare configuration indexes, past the calibration words
	localparam logic [bpc_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [bpc_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// calibration presets used by the directed part
	localparam logic [2:0] PRESET_RESET   = 3'd0;
	localparam logic [2:0] PRESET_TYPICAL = 3'd1;
	localparam logic [2:0] PRESET_MAX     = 3'd2;
	localparam logic [2:0] PRESET_HOT     = 3'd3;
	localparam logic [2:0] PRESET_COLD    = 3'd4;
	localparam logic [2:0] PRESET_KNEE    = 3'd5;

	// sens, offset, sens_tc, offset_tc, ref_temp, temp_slope
	localparam bpc_pkg::coeff_t PRESETS [6] = '{
		'{16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0},
		'{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312},
		'{16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF},
		// only the slope: temperature runs hot, pressure terms stay zero
		'{16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'hFFFF},
		// high reference and slope: deep in the extra-cold range
		'{16'd0,     16'd0,     16'd0,     16'd0,     16'hFFFF,  16'hFFFF},
		// slope 2^15 around a reference of 2^23: one 0.01 C step per 256 counts
		'{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd32768, 16'd32768}
	};

	typedef struct packed {
		logic signed [bpc_pkg::TEMP_W-1:0] temp;
		logic [bpc_pkg::PRESS_W-1:0]       press;
		logic                              ok;
	} comp_reading_t;

	typedef struct packed {
		logic [bpc_pkg::RAW_W-1:0]         d1;
		logic [bpc_pkg::RAW_W-1:0]         d2;
		logic [2:0]                        preset;
		logic                              typed;    // expected fields given below
		logic signed [bpc_pkg::TEMP_W-1:0] temp;
		logic [bpc_pkg::PRESS_W-1:0]       press;
		logic                              ok;
	} probe_t;

	// Directed stimulus. Rows with typed set carry results that follow from
	// the calibration at a glance; the rest go through the predictor.
	localparam probe_t PROBES [22] = '{
		// reset calibration: temperature pinned at 20.00 C, pressure zero
		'{24'd1,       24'd1,       PRESET_RESET,   1'b1, 15'sd2000, 17'd0, 1'b1},
		'{24'hFFFFFF,  24'hFFFFFF,  PRESET_RESET,   1'b1, 15'sd2000, 17'd0, 1'b1},
		// zero readings flag the result and clear both fields
		'{24'd0,       24'd5,       PRESET_RESET,   1'b1, 15'sd0,    17'd0, 1'b0},
		'{24'd5,       24'd0,       PRESET_RESET,   1'b1, 15'sd0,    17'd0, 1'b0},
		'{24'd0,       24'd0,       PRESET_RESET,   1'b1, 15'sd0,    17'd0, 1'b0},
		'{24'd9085466, 24'd8569150, PRESET_TYPICAL, 1'b0, 15'sd0,    17'd0, 1'b0},
		'{24'hFFFFFF,  24'd8569150, PRESET_TYPICAL, 1'b0, 15'sd0,    17'd0, 1'b0},
		'{24'd1,       24'd8569150, PRESET_TYPICAL, 1'b0, 15'sd0,    17'd0, 1'b0},
		'{24'd9085466, 24'd1,       PRESET_TYPICAL, 1'b0, 15'sd0,    17'd0, 1'b0},
		'{24'd0,       24'd8569150, PRESET_TYPICAL, 1'b1, 15'sd0,    17'd0, 1'b0},
		'{24'hFFFFFF,  24'hFFFFFF,  PRESET_MAX,     1'b0, 15'sd0,    17'd0, 1'b0},
		'{24'd1,       24'd1,       PRESET_MAX,     1'b0, 15'sd0,    17'd0, 1'b0},
		'{24'h800000,  24'h800000,  PRESET_MAX,     1'b0, 15'sd0,    17'd0, 1'b0},
		// hot preset, saturating at full scale; pressure terms all zero
		'{24'hFFFFFF,  24'hFFFFFF,  PRESET_HOT,     1'b1, 15'sd8500, 17'd0, 1'b1},
		'{24'd123456,  24'd1,       PRESET_HOT,     1'b1, 15'sd2000, 17'd0, 1'b1},
		// cold saturation with both second-order terms
		'{24'hFFFFFF,  24'd1,       PRESET_COLD,    1'b0, 15'sd0,    17'd0, 1'b0},
		'{24'd1,       24'd0,       PRESET_COLD,    1'b1, 15'sd0,    17'd0, 1'b0},
		// knees: exactly 20.00 C, just below, exactly -15.00 C, just below
		'{24'd9085466, 24'd8388608, PRESET_KNEE,    1'b0, 15'sd0,    17'd0, 1'b0},
		'{24'd9085466, 24'd8388607, PRESET_KNEE,    1'b0, 15'sd0,    17'd0, 1'b0},
		'{24'd9085466, 24'd7492608, PRESET_KNEE,    1'b0, 15'sd0,    17'd0, 1'b0},
		'{24'd9085466, 24'd7492607, PRESET_KNEE,    1'b0, 15'sd0,    17'd0, 1'b0},
		'{24'd9085466, 24'd0,       PRESET_KNEE,    1'b1, 15'sd0,    17'd0, 1'b0}
	};

	// ------------------------------------------------------------------------
	// DUT signals
	// ------------------------------------------------------------------------
	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_stall;
	logic [bpc_pkg::RAW_W-1:0]         raw_pressure;
	logic [bpc_pkg::RAW_W-1:0]         raw_temperature;
	logic                              out_valid;
	logic                              out_stall;
	logic signed [bpc_pkg::TEMP_W-1:0] temp_centideg;
	logic [bpc_pkg::PRESS_W-1:0]       press_centimbar;
	logic                              valid_res;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [bpc_pkg::REG_IDX_W-1:0]     cfg_index;
	logic [bpc_pkg::COEFF_W-1:0]       cfg_data;

	// bench state
	bpc_pkg::coeff_t cal;                  // calibration words as last written
	comp_reading_t   pending_readings [$]; // readings owed by the block, oldest first
	int              n_offered;
	int              n_readings;
	int              n_mismatch;
	int              hold_left;

	baro_pressure_temp_compensation dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.temp_centideg   (temp_centideg),
		.press_centimbar (press_centimbar),
		.valid_res       (valid_res),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------------
	// Predictor: second-order compensation in exact 64-bit signed math.
	// Every >>> here is on a signed longint, so it rounds toward minus infinity.
	// ------------------------------------------------------------------------
	function automatic comp_reading_t compensate(input logic [bpc_pkg::RAW_W-1:0] d1,
			input logic [bpc_pkg::RAW_W-1:0] d2, input bpc_pkg::coeff_t c);
		comp_reading_t r;
		longint p, t, dt, off, sens, temp, off2, sens2, sq, press;
		r = '0;
		// a zero reading yields a flagged, cleared result
		if (d1 == '0 || d2 == '0)
			return r;
		p    = longint'({40'd0, d1});
		t    = longint'({40'd0, d2});
		dt   = t - longint'({48'd0, c.ref_temp}) * 256;
		off  = longint'({48'd0, c.offset}) * 65536
			+ ((dt * longint'({48'd0, c.offset_tc})) >>> 7);
		sens = longint'({48'd0, c.sens}) * 32768
			+ ((dt * longint'({48'd0, c.sens_tc})) >>> 8);
		temp = longint'(bpc_pkg::TEMP_REF)
			+ ((dt * longint'({48'd0, c.temp_slope})) >>> 23);
		off2  = 0;
		sens2 = 0;
		// the range decisions use the unsaturated first-order temperature
		if (temp < longint'(bpc_pkg::TEMP_REF)) begin
			sq    = (temp - longint'(bpc_pkg::TEMP_REF))
				* (temp - longint'(bpc_pkg::TEMP_REF));
			off2  = (5 * sq) >>> 1;
			sens2 = (5 * sq) >>> 2;
			if (temp < longint'(bpc_pkg::TEMP_XCOLD)) begin
				sq    = (temp - longint'(bpc_pkg::TEMP_XCOLD))
					* (temp - longint'(bpc_pkg::TEMP_XCOLD));
				off2  = off2 + 7 * sq;
				sens2 = sens2 + ((11 * sq) >>> 1);
			end
		end
		off   = off - off2;
		sens  = sens - sens2;
		press = (((p * sens) >>> 21) - off) >>> 15;
		// saturate both outputs
		if (temp < longint'(bpc_pkg::TEMP_LO))
			temp = longint'(bpc_pkg::TEMP_LO);
		if (temp > longint'(bpc_pkg::TEMP_HI))
			temp = longint'(bpc_pkg::TEMP_HI);
		if (press < 0)
			press = 0;
		if (press > longint'(bpc_pkg::PRESS_HI))
			press = longint'(bpc_pkg::PRESS_HI);
		r.temp  = temp[bpc_pkg::TEMP_W-1:0];
		r.press = press[bpc_pkg::PRESS_W-1:0];
		r.ok    = 1'b1;
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch: %s", msg);
		n_mismatch++;
	endtask

	// ------------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------------

	// Offer one pair: idle at random first (except in the calm window), then
	// hold the beat until the block takes it and log what it owes us.
	task automatic offer_pair(input logic [bpc_pkg::RAW_W-1:0] d1,
			input logic [bpc_pkg::RAW_W-1:0] d2, input comp_reading_t want);
		while (!(n_offered >= CALM_LO && n_offered < CALM_HI)
				&& $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		raw_pressure    <= d1;
		raw_temperature <= d2;
		do
			@(posedge clk);
		while (in_stall);
		pending_readings.push_back(want);
		n_offered++;
	endtask

	// Wait until every owed reading has come back; the pipeline is then empty.
	task automatic drain();
		while (pending_readings.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [bpc_pkg::REG_IDX_W-1:0] idx,
			input logic [bpc_pkg::COEFF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			bpc_pkg::REG_SENS:       cal.sens       = data;
			bpc_pkg::REG_OFFSET:     cal.offset     = data;
			bpc_pkg::REG_SENS_TC:    cal.sens_tc    = data;
			bpc_pkg::REG_OFFSET_TC:  cal.offset_tc  = data;
			bpc_pkg::REG_REF_TEMP:   cal.ref_temp   = data;
			bpc_pkg::REG_TEMP_SLOPE: cal.temp_slope = data;
			default: ;  // spare indexes: drop the write
		endcase
	endtask

	// Load a full calibration set once the block has gone idle, plus a write
	// to each spare index that must leave the calibration untouched.
	task automatic apply_coeffs(input bpc_pkg::coeff_t c);
		in_valid <= 1'b0;
		drain();
		cfg_write(bpc_pkg::REG_SENS,       c.sens);
		cfg_write(bpc_pkg::REG_OFFSET,     c.offset);
		cfg_write(bpc_pkg::REG_SENS_TC,    c.sens_tc);
		cfg_write(bpc_pkg::REG_OFFSET_TC,  c.offset_tc);
		cfg_write(bpc_pkg::REG_REF_TEMP,   c.ref_temp);
		cfg_write(bpc_pkg::REG_TEMP_SLOPE, c.temp_slope);
		cfg_write(REG_SPARE_LO,            bpc_pkg::COEFF_W'($urandom));
		cfg_write(REG_SPARE_HI,            bpc_pkg::COEFF_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		comp_reading_t             want;
		bpc_pkg::coeff_t           c;
		logic [bpc_pkg::RAW_W-1:0] d1, d2;
		logic [2:0]                cur_preset;
		int                        pick;

		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		raw_pressure    <= '0;
		raw_temperature <= '0;
		cfg_valid       <= 1'b0;
		cfg_index       <= '0;
		cfg_data        <= '0;
		cal        = PRESETS[PRESET_RESET];
		n_offered  = 0;
		n_mismatch = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: walk the probe table, reloading calibration on change.
		cur_preset = PRESET_RESET;
		for (int i = 0; i < $size(PROBES); i++) begin
			if (PROBES[i].preset != cur_preset) begin
				apply_coeffs(PRESETS[PROBES[i].preset]);
				cur_preset = PROBES[i].preset;
			end
			if (PROBES[i].typed) begin
				want.temp  = PROBES[i].temp;
				want.press = PROBES[i].press;
				want.ok    = PROBES[i].ok;
			end else begin
				want = compensate(PROBES[i].d1, PROBES[i].d2, cal);
			end
			offer_pair(PROBES[i].d1, PROBES[i].d2, want);
		end

		// Random part: one calibration per phase, extremes among them.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				1:       c = PRESETS[PRESET_MAX];
				2:       c = PRESETS[PRESET_RESET];
				4:       c = PRESETS[PRESET_TYPICAL];
				default: c = bpc_pkg::coeff_t'({$urandom, $urandom, $urandom});
			endcase
			apply_coeffs(c);
			repeat (PHASE_ITEMS) begin
				d1   = bpc_pkg::RAW_W'($urandom);
				d2   = bpc_pkg::RAW_W'($urandom);
				pick = $urandom_range(99);
				if (pick < 4) begin
					d1 = '0;
				end else if (pick < 8) begin
					d2 = '0;
				end else if (pick < 14) begin
					d1 = '1;
					d2 = $urandom_range(1) ? bpc_pkg::RAW_W'(1) : '1;
				end else if (pick < 45) begin
					// land near the reference temperature so both knees are crossed
					d2 = {cal.ref_temp, 8'd0} + bpc_pkg::RAW_W'($urandom_range(2097151))
						- bpc_pkg::RAW_W'(1048576);
				end
				offer_pair(d1, d2, compensate(d1, d2, cal));
			end
		end

		// Drop valid, let the last readings come back, then watch for strays.
		in_valid <= 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_mismatch == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver side: check each accepted beat, then pick the next stall.
	// ------------------------------------------------------------------------
	task automatic check_reading();
		comp_reading_t want;
		if (pending_readings.size() == 0) begin
			flag_mismatch($sformatf("reading %0d arrived with nothing pending", n_readings));
		end else begin
			want = pending_readings.pop_front();
			if (temp_centideg !== want.temp)
				flag_mismatch($sformatf("reading %0d temp_centideg got %0d want %0d",
					n_readings, temp_centideg, want.temp));
			if (press_centimbar !== want.press)
				flag_mismatch($sformatf("reading %0d press_centimbar got %0d want %0d",
					n_readings, press_centimbar, want.press));
			if (valid_res !== want.ok)
				flag_mismatch($sformatf("reading %0d valid_res got %b want %b",
					n_readings, valid_res, want.ok));
		end
		n_readings++;
	endtask

	initial begin
		out_stall <= 1'b0;
		n_readings = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				check_reading();
				// long hold-off: the sender keeps going, so the block backs up
				if (n_readings == HOLD_A || n_readings == HOLD_B)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (n_readings >= CALM_LO && n_readings < CALM_HI) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule
